[src/disparity_to_world_point_macros.svh]
// Assertion macros shared by the disparity reprojection RTL.
`ifndef DISPARITY_TO_WORLD_POINT_MACROS_SVH
`define DISPARITY_TO_WORLD_POINT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DTWP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define DTWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dtwp_pkg.sv]
// Shared constants, codes and arithmetic helpers for the disparity reprojection block.
package dtwp_pkg;

    localparam int COORD_BITS = 12;
    localparam int DISP_BITS  = 16;

    // input stream layout (tdata, lowest bit first)
    localparam int OFF_SLOT   = 0;
    localparam int OFF_PVAL   = 3;
    localparam int OFF_DISP   = OFF_PVAL + 32;
    localparam int OFF_COL    = OFF_DISP + DISP_BITS;
    localparam int OFF_ROW    = OFF_COL + COORD_BITS;
    localparam int OFF_COLOR  = OFF_ROW + COORD_BITS;
    localparam int IN_BITS    = OFF_COLOR + 24;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 120;

    // datapath widths
    localparam int FB_W       = 44;
    localparam int DIFF_W     = ((COORD_BITS + 8 > 20) ? COORD_BITS + 8 : 20) + 1;
    localparam int PX_W       = DIFF_W + 21;
    localparam int DIV_W      = DISP_BITS;
    localparam int DVD_W      = 44;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DVD_W / DIV_STEP;

    // command codes
    localparam logic CMD_POSE  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // pose slots
    localparam logic [2:0] SLOT_QX   = 3'd0;
    localparam logic [2:0] SLOT_QY   = 3'd1;
    localparam logic [2:0] SLOT_QZ   = 3'd2;
    localparam logic [2:0] SLOT_QW   = 3'd3;
    localparam logic [2:0] SLOT_PN   = 3'd4;
    localparam logic [2:0] SLOT_PE   = 3'd5;
    localparam logic [2:0] SLOT_PD   = 3'd6;
    localparam logic [2:0] SLOT_NONE = 3'd7;

    typedef enum logic [2:0] {
        CFG_FOCAL    = 3'd0,
        CFG_CCOL     = 3'd1,
        CFG_CROW     = 3'd2,
        CFG_BASELINE = 3'd3,
        CFG_DMIN     = 3'd4,
        CFG_DMAX     = 3'd5,
        CFG_NEG      = 3'd6,
        CFG_BACK     = 3'd7
    } t_cfg_idx;

    localparam logic [23:0] RST_FOCAL    = 24'd106417;
    localparam logic [19:0] RST_CCOL     = 20'd61440;
    localparam logic [19:0] RST_CROW     = 20'd46080;
    localparam logic [19:0] RST_BASELINE = 20'd19661;
    localparam logic [30:0] RST_DMIN     = 31'd26214;
    localparam logic [30:0] RST_DMAX     = 31'd2621440;

    localparam logic signed [47:0] OFFSET_FWD  = 48'sd11469;
    localparam logic signed [47:0] OFFSET_SIDE = -48'sd9830;
    localparam logic [65:0]        QUAT_SMALL  = 66'd1152921;
    localparam logic signed [36:0] ONE_Q30     = 37'sh0040000000;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh00007FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (v < 48'shFFFF80000000)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Q.60 product to Q.30, round half up
    function automatic logic signed [33:0] round30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sh0000000020000000;
        return t[63:30];
    endfunction

    function automatic logic signed [31:0] clamp_one(input logic signed [36:0] v);
        if (v > ONE_Q30)
            return 32'sh40000000;
        else if (v < -ONE_Q30)
            return 32'shC0000000;
        else
            return v[31:0];
    endfunction

    // diagonal entry: 1 - 2(a+b)
    function automatic logic signed [31:0] mat_diag(input logic signed [33:0] a,
                                                    input logic signed [33:0] b);
        logic signed [36:0] s;
        s = ONE_Q30 - ((37'(a) + 37'(b)) <<< 1);
        return clamp_one(s);
    endfunction

    // off-diagonal entry: 2(a+b) or 2(a-b)
    function automatic logic signed [31:0] mat_off(input logic signed [33:0] a,
                                                   input logic signed [33:0] b,
                                                   input logic sub);
        logic signed [36:0] s;
        s = sub ? (37'(a) - 37'(b)) : (37'(a) + 37'(b));
        return clamp_one(s <<< 1);
    endfunction

endpackage

[src/disparity_to_world_point.sv]
// Top level: stereo disparity pixel to world point reprojection pipeline.
//
// Usage
//   Slave stream carries requests. tuser = command (0 pose load, 1 pixel).
//   Pose request: tdata slot and value; slots 0-3 quaternion x,y,z,w (Q1.30),
//   4-6 position N,E,D (Q15.16); slot 7 ignored. Takes effect for every pixel
//   accepted after it.
//   Pixel request: disparity (Q.4), column, row, color. Produces one point on
//   the master stream, or nothing when the disparity is too small, no usable
//   pose is loaded, or the depth falls outside [depth_min, depth_max].
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_index; write
//   only while the pipeline is empty.
// Pipeline
//   20 register stages from the accepting edge to o_m_axis_tvalid.
//   One request per cycle while not stalled; the three divisions run in 11-stage
//   pipelined dividers (4 quotient bits per stage), other stages one multiply deep.
// Reset: synchronous, active low; pipeline emptied, no pose loaded, config defaults.
// Stall: while a point waits and the receiver is not ready, the whole pipeline
//   holds and o_s_axis_tready is low; nothing is lost or repeated.
`include "disparity_to_world_point_macros.svh"

module disparity_to_world_point (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: pose_slot, pose_value, raw_disparity, pixel_col, pixel_row,
    //        pixel_color, zero pad
    input  logic [dtwp_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: command
    input  logic                              i_s_axis_tuser,
    // master stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: world_x, world_y, world_z, point_color
    output logic [dtwp_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [30:0]                       i_cfg_data
);

    localparam int V_X1 = 3 + dtwp_pkg::DIV_STAGES;
    localparam int NV   = V_X1 + 5;

    typedef struct packed {
        logic             disp_low;
        logic             pose_ok;
        logic             sign_x;
        logic             sign_y;
        logic [3:0][31:0] q;
        logic [2:0][31:0] p;
        logic [23:0]      color;
    } t_side;

    typedef struct packed {
        logic signed [dtwp_pkg::DISP_BITS:0] d;
        logic [dtwp_pkg::COORD_BITS-1:0]     col;
        logic [dtwp_pkg::COORD_BITS-1:0]     row;
        t_side                               side;
    } t_s0;

    typedef struct packed {
        logic [dtwp_pkg::FB_W-1:0]        prod_d;
        logic signed [dtwp_pkg::PX_W-1:0] prod_x;
        logic signed [dtwp_pkg::PX_W-1:0] prod_y;
        logic [dtwp_pkg::DIV_W-1:0]       dmag;
        t_side                            side;
    } t_s1;

    typedef struct packed {
        logic [dtwp_pkg::DVD_W-1:0] num_d;
        logic [dtwp_pkg::DVD_W-1:0] num_x;
        logic [dtwp_pkg::DVD_W-1:0] num_y;
        logic [dtwp_pkg::DIV_W-1:0] dmag;
    } t_s2;

    typedef struct packed {
        logic signed [63:0] xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
    } t_qprod;

    typedef struct packed {
        logic signed [33:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
    } t_pq;

    typedef struct packed {
        logic [2:0][31:0] b;
        t_qprod           qp;
        logic [2:0][31:0] p;
        logic [23:0]      color;
        logic             keep;
    } t_x1;

    typedef struct packed {
        logic [2:0][31:0] b;
        t_pq              pq;
        logic [2:0][31:0] p;
        logic [23:0]      color;
        logic             keep;
    } t_x2;

    typedef struct packed {
        logic [2:0][31:0] b;
        logic [8:0][31:0] r;   // row-major rotation, Q.30
        logic [2:0][31:0] p;
        logic [23:0]      color;
        logic             keep;
    } t_x3;

    typedef struct packed {
        logic [8:0][63:0] m;
        logic [2:0][31:0] p;
        logic [23:0]      color;
        logic             keep;
    } t_x4;

    typedef struct packed {
        logic [2:0][47:0] ned;
        logic [23:0]      color;
        logic             keep;
    } t_x5;

    // config
    logic [23:0] r_focal;
    logic [19:0] r_ccol, r_crow, r_baseline;
    logic [30:0] r_dmin, r_dmax;
    logic        r_neg, r_back;

    // pose
    logic signed [31:0] r_quat [4];
    logic signed [31:0] r_pos  [3];
    logic               r_pose_loaded;

    // pipeline
    logic [NV-1:0] r_vld;
    t_s0           r_s0, n_s0;
    t_s1           r_s1, n_s1;
    t_s2           r_s2, n_s2;
    t_side         r_s2_side, n_s2_side;
    t_side         r_line [dtwp_pkg::DIV_STAGES];
    t_x1           r_x1, n_x1;
    t_x2           r_x2, n_x2;
    t_x3           r_x3, n_x3;
    t_x4           r_x4, n_x4;
    t_x5           r_x5, n_x5;
    logic          r_out_vld;
    logic [31:0]   r_out_x, r_out_y, r_out_z;
    logic [23:0]   r_out_color;

    logic                              en, in_acc, in_pix, in_pose;
    logic [2:0]                        in_slot;
    logic [31:0]                       in_pval;
    logic signed [dtwp_pkg::DISP_BITS-1:0] in_disp;
    logic [dtwp_pkg::DVD_W-1:0]        q_d, q_x, q_y;

    assign en              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign in_acc          = i_s_axis_tvalid && en;
    assign in_pix          = in_acc && (i_s_axis_tuser == dtwp_pkg::CMD_PIXEL);
    assign in_pose         = in_acc && (i_s_axis_tuser == dtwp_pkg::CMD_POSE);
    assign in_slot         = i_s_axis_tdata[dtwp_pkg::OFF_SLOT +: 3];
    assign in_pval         = i_s_axis_tdata[dtwp_pkg::OFF_PVAL +: 32];
    assign in_disp         = i_s_axis_tdata[dtwp_pkg::OFF_DISP +: dtwp_pkg::DISP_BITS];

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal    <= dtwp_pkg::RST_FOCAL;
            r_ccol     <= dtwp_pkg::RST_CCOL;
            r_crow     <= dtwp_pkg::RST_CROW;
            r_baseline <= dtwp_pkg::RST_BASELINE;
            r_dmin     <= dtwp_pkg::RST_DMIN;
            r_dmax     <= dtwp_pkg::RST_DMAX;
            r_neg      <= 1'b0;
            r_back     <= 1'b0;
        end else if (i_cfg_we) begin
            case (dtwp_pkg::t_cfg_idx'(i_cfg_index))
                dtwp_pkg::CFG_FOCAL:    r_focal    <= i_cfg_data[23:0];
                dtwp_pkg::CFG_CCOL:     r_ccol     <= i_cfg_data[19:0];
                dtwp_pkg::CFG_CROW:     r_crow     <= i_cfg_data[19:0];
                dtwp_pkg::CFG_BASELINE: r_baseline <= i_cfg_data[19:0];
                dtwp_pkg::CFG_DMIN:     r_dmin     <= i_cfg_data;
                dtwp_pkg::CFG_DMAX:     r_dmax     <= i_cfg_data;
                dtwp_pkg::CFG_NEG:      r_neg      <= i_cfg_data[0];
                dtwp_pkg::CFG_BACK:     r_back     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pose store ----------------
    // Pixels snapshot the pose at accept time, so later loads never reach
    // points already in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_quat[i] <= '0;
            for (int i = 0; i < 3; i++) r_pos[i]  <= '0;
            r_pose_loaded <= 1'b0;
        end else if (in_pose) begin
            case (in_slot)
                dtwp_pkg::SLOT_QX, dtwp_pkg::SLOT_QY,
                dtwp_pkg::SLOT_QZ, dtwp_pkg::SLOT_QW: begin
                    r_quat[in_slot[1:0]] <= in_pval;
                    r_pose_loaded        <= 1'b1;
                end
                dtwp_pkg::SLOT_PN, dtwp_pkg::SLOT_PE, dtwp_pkg::SLOT_PD: begin
                    r_pos[in_slot[1:0]] <= in_pval;
                    r_pose_loaded       <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NV-2:0], in_pix};
            r_out_vld <= r_vld[NV-1] && r_x5.keep;
        end
    end

    // ---------------- S0: capture, sign fix, small check ----------------
    always_comb begin
        logic signed [dtwp_pkg::DISP_BITS:0] d_ext;
        d_ext = {in_disp[dtwp_pkg::DISP_BITS-1], in_disp};
        n_s0.d   = r_neg ? -d_ext : d_ext;
        n_s0.col = i_s_axis_tdata[dtwp_pkg::OFF_COL +: dtwp_pkg::COORD_BITS];
        n_s0.row = i_s_axis_tdata[dtwp_pkg::OFF_ROW +: dtwp_pkg::COORD_BITS];
        n_s0.side.disp_low = (n_s0.d <= $signed((dtwp_pkg::DISP_BITS+1)'(1)));
        n_s0.side.pose_ok  = r_pose_loaded;
        n_s0.side.sign_x   = 1'b0;
        n_s0.side.sign_y   = 1'b0;
        for (int i = 0; i < 4; i++) n_s0.side.q[i] = r_quat[i];
        for (int i = 0; i < 3; i++) n_s0.side.p[i] = r_pos[i];
        n_s0.side.color = i_s_axis_tdata[dtwp_pkg::OFF_COLOR +: 24];
    end

    // ---------------- S1: fx*B and offset*B products ----------------
    always_comb begin
        logic signed [dtwp_pkg::DIFF_W-1:0] dx, dy;
        dx = $signed(dtwp_pkg::DIFF_W'({r_s0.col, 8'h00})) - $signed(dtwp_pkg::DIFF_W'(r_ccol));
        dy = $signed(dtwp_pkg::DIFF_W'({r_s0.row, 8'h00})) - $signed(dtwp_pkg::DIFF_W'(r_crow));
        n_s1.prod_d = dtwp_pkg::FB_W'(r_focal) * dtwp_pkg::FB_W'(r_baseline);
        n_s1.prod_x = dx * $signed({1'b0, r_baseline});
        n_s1.prod_y = dy * $signed({1'b0, r_baseline});
        n_s1.dmag   = r_s0.d[dtwp_pkg::DIV_W-1:0];
        n_s1.side   = r_s0.side;
    end

    // ---------------- S2: rounding bias, fold the factor of 16 ----------------
    // (n + 8d) / 16d == ((n + 8d) >> 4) / d
    always_comb begin
        logic [dtwp_pkg::FB_W:0]   td;
        logic [dtwp_pkg::PX_W-1:0] mx, my;
        logic [dtwp_pkg::PX_W:0]   tx, ty;
        logic [dtwp_pkg::DIV_W+2:0] bias;
        bias = {r_s1.dmag, 3'b000};
        td   = (dtwp_pkg::FB_W+1)'(r_s1.prod_d) + (dtwp_pkg::FB_W+1)'(bias);
        mx   = r_s1.prod_x[dtwp_pkg::PX_W-1] ? dtwp_pkg::PX_W'(-r_s1.prod_x)
                                              : dtwp_pkg::PX_W'(r_s1.prod_x);
        my   = r_s1.prod_y[dtwp_pkg::PX_W-1] ? dtwp_pkg::PX_W'(-r_s1.prod_y)
                                              : dtwp_pkg::PX_W'(r_s1.prod_y);
        tx   = (dtwp_pkg::PX_W+1)'(mx) + (dtwp_pkg::PX_W+1)'(bias);
        ty   = (dtwp_pkg::PX_W+1)'(my) + (dtwp_pkg::PX_W+1)'(bias);
        n_s2.num_d = dtwp_pkg::DVD_W'(td >> 4);
        n_s2.num_x = dtwp_pkg::DVD_W'(tx >> 4);
        n_s2.num_y = dtwp_pkg::DVD_W'(ty >> 4);
        n_s2.dmag  = r_s1.dmag;
        n_s2_side        = r_s1.side;
        n_s2_side.sign_x = r_s1.prod_x[dtwp_pkg::PX_W-1];
        n_s2_side.sign_y = r_s1.prod_y[dtwp_pkg::PX_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0      <= n_s0;
            r_s1      <= n_s1;
            r_s2      <= n_s2;
            r_s2_side <= n_s2_side;
        end
    end

    // ---------------- dividers, sideband rides alongside ----------------
    dtwp_divider u_div_depth (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_s2.num_d),
        .i_divisor  (r_s2.dmag),
        .o_quotient (q_d)
    );

    dtwp_divider u_div_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_s2.num_x),
        .i_divisor  (r_s2.dmag),
        .o_quotient (q_x)
    );

    dtwp_divider u_div_y (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_s2.num_y),
        .i_divisor  (r_s2.dmag),
        .o_quotient (q_y)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_line[0] <= r_s2_side;
            for (int k = 1; k < dtwp_pkg::DIV_STAGES; k++) r_line[k] <= r_line[k-1];
        end
    end

    // ---------------- X1: depth window, body point, quaternion products ----------------
    always_comb begin
        t_side              sd;
        logic signed [47:0] dep, xo, yo;
        logic               dok;
        sd  = r_line[dtwp_pkg::DIV_STAGES-1];
        dep = $signed(48'(q_d));
        xo  = sd.sign_x ? -$signed(48'(q_x)) : $signed(48'(q_x));
        yo  = sd.sign_y ? -$signed(48'(q_y)) : $signed(48'(q_y));
        dok = (q_d >= dtwp_pkg::DVD_W'(r_dmin)) && (q_d <= dtwp_pkg::DVD_W'(r_dmax));
        if (r_back) begin
            n_x1.b[0] = dtwp_pkg::sat32(-dtwp_pkg::OFFSET_FWD - dep);
            n_x1.b[1] = dtwp_pkg::sat32(dtwp_pkg::OFFSET_SIDE - xo);
        end else begin
            n_x1.b[0] = dtwp_pkg::sat32(dtwp_pkg::OFFSET_FWD + dep);
            n_x1.b[1] = dtwp_pkg::sat32(dtwp_pkg::OFFSET_SIDE + xo);
        end
        n_x1.b[2]  = dtwp_pkg::sat32(yo);
        n_x1.qp.xx = $signed(sd.q[0]) * $signed(sd.q[0]);
        n_x1.qp.yy = $signed(sd.q[1]) * $signed(sd.q[1]);
        n_x1.qp.zz = $signed(sd.q[2]) * $signed(sd.q[2]);
        n_x1.qp.ww = $signed(sd.q[3]) * $signed(sd.q[3]);
        n_x1.qp.xy = $signed(sd.q[0]) * $signed(sd.q[1]);
        n_x1.qp.xz = $signed(sd.q[0]) * $signed(sd.q[2]);
        n_x1.qp.yz = $signed(sd.q[1]) * $signed(sd.q[2]);
        n_x1.qp.xw = $signed(sd.q[0]) * $signed(sd.q[3]);
        n_x1.qp.yw = $signed(sd.q[1]) * $signed(sd.q[3]);
        n_x1.qp.zw = $signed(sd.q[2]) * $signed(sd.q[3]);
        n_x1.p     = sd.p;
        n_x1.color = sd.color;
        n_x1.keep  = !sd.disp_low && sd.pose_ok && dok;
    end

    // ---------------- X2: round products, near-zero quaternion test ----------------
    always_comb begin
        logic [65:0] sq;
        sq = 66'(r_x1.qp.xx) + 66'(r_x1.qp.yy) + 66'(r_x1.qp.zz) + 66'(r_x1.qp.ww);
        n_x2.pq.xx = dtwp_pkg::round30(r_x1.qp.xx);
        n_x2.pq.yy = dtwp_pkg::round30(r_x1.qp.yy);
        n_x2.pq.zz = dtwp_pkg::round30(r_x1.qp.zz);
        n_x2.pq.xy = dtwp_pkg::round30(r_x1.qp.xy);
        n_x2.pq.xz = dtwp_pkg::round30(r_x1.qp.xz);
        n_x2.pq.yz = dtwp_pkg::round30(r_x1.qp.yz);
        n_x2.pq.xw = dtwp_pkg::round30(r_x1.qp.xw);
        n_x2.pq.yw = dtwp_pkg::round30(r_x1.qp.yw);
        n_x2.pq.zw = dtwp_pkg::round30(r_x1.qp.zw);
        n_x2.b     = r_x1.b;
        n_x2.p     = r_x1.p;
        n_x2.color = r_x1.color;
        n_x2.keep  = r_x1.keep && (sq > dtwp_pkg::QUAT_SMALL);
    end

    // ---------------- X3: rotation matrix, clamped to [-1, 1] ----------------
    always_comb begin
        n_x3.r[0] = dtwp_pkg::mat_diag(r_x2.pq.yy, r_x2.pq.zz);
        n_x3.r[1] = dtwp_pkg::mat_off(r_x2.pq.xy, r_x2.pq.zw, 1'b1);
        n_x3.r[2] = dtwp_pkg::mat_off(r_x2.pq.xz, r_x2.pq.yw, 1'b0);
        n_x3.r[3] = dtwp_pkg::mat_off(r_x2.pq.xy, r_x2.pq.zw, 1'b0);
        n_x3.r[4] = dtwp_pkg::mat_diag(r_x2.pq.xx, r_x2.pq.zz);
        n_x3.r[5] = dtwp_pkg::mat_off(r_x2.pq.yz, r_x2.pq.xw, 1'b1);
        n_x3.r[6] = dtwp_pkg::mat_off(r_x2.pq.xz, r_x2.pq.yw, 1'b1);
        n_x3.r[7] = dtwp_pkg::mat_off(r_x2.pq.yz, r_x2.pq.xw, 1'b0);
        n_x3.r[8] = dtwp_pkg::mat_diag(r_x2.pq.xx, r_x2.pq.yy);
        n_x3.b     = r_x2.b;
        n_x3.p     = r_x2.p;
        n_x3.color = r_x2.color;
        n_x3.keep  = r_x2.keep;
    end

    // ---------------- X4: nine rotation products ----------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_x4.m[3*i+j] = $signed(r_x3.r[3*i+j]) * $signed(r_x3.b[j]);
            end
        end
        n_x4.p     = r_x3.p;
        n_x4.color = r_x3.color;
        n_x4.keep  = r_x3.keep;
    end

    // ---------------- X5: sum, round to Q.16, add position ----------------
    always_comb begin
        logic signed [65:0] acc;
        for (int i = 0; i < 3; i++) begin
            acc = $signed(66'($signed(r_x4.m[3*i])))
                + $signed(66'($signed(r_x4.m[3*i+1])))
                + $signed(66'($signed(r_x4.m[3*i+2])))
                + 66'sh20000000;
            n_x5.ned[i] = 48'($signed(acc[65:30])) + 48'($signed(r_x4.p[i]));
        end
        n_x5.color = r_x4.color;
        n_x5.keep  = r_x4.keep;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1 <= n_x1;
            r_x2 <= n_x2;
            r_x3 <= n_x3;
            r_x4 <= n_x4;
            r_x5 <= n_x5;
            // NED to world axes
            r_out_x     <= dtwp_pkg::sat32($signed(r_x5.ned[0]));
            r_out_y     <= dtwp_pkg::sat32(-$signed(r_x5.ned[1]));
            r_out_z     <= dtwp_pkg::sat32(-$signed(r_x5.ned[2]));
            r_out_color <= r_x5.color;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_color, r_out_z, r_out_y, r_out_x};

    // ---------------- checks ----------------
    `DTWP_ASSERT_NOW(a_stall_blocks_input, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready, "output stall did not hold off input")
    `DTWP_ASSERT_NEXT(a_stall_freezes_pipe, !en, $stable(r_vld), "pipeline moved during stall")
    `DTWP_ASSERT_NEXT(a_pixel_enters, in_pix, r_vld[0], "accepted pixel did not enter pipeline")
    `DTWP_ASSERT_NEXT(a_pose_sets_loaded, in_pose && (in_slot != dtwp_pkg::SLOT_NONE), r_pose_loaded, "pose load did not mark pose loaded")

endmodule

[src/dtwp_divider.sv]
// Pipelined restoring divider, DIV_STEP (4) quotient bits per stage, stalls on i_en low.
module dtwp_divider (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [dtwp_pkg::DVD_W-1:0]  i_dividend,
    input  logic [dtwp_pkg::DIV_W-1:0]  i_divisor,
    output logic [dtwp_pkg::DVD_W-1:0]  o_quotient
);

    typedef struct packed {
        logic [dtwp_pkg::DVD_W-1:0] num;   // dividend bits shifting out, quotient in
        logic [dtwp_pkg::DIV_W-1:0] rem;
        logic [dtwp_pkg::DIV_W-1:0] dvs;
    } t_div;

    function automatic t_div div_steps(input t_div st);
        t_div                     o;
        logic [dtwp_pkg::DIV_W:0] sh;
        o = st;
        for (int k = 0; k < dtwp_pkg::DIV_STEP; k++) begin
            sh    = {o.rem, o.num[dtwp_pkg::DVD_W-1]};
            o.num = {o.num[dtwp_pkg::DVD_W-2:0], 1'b0};
            if (sh >= {1'b0, o.dvs}) begin
                sh       = sh - {1'b0, o.dvs};
                o.num[0] = 1'b1;
            end
            o.rem = sh[dtwp_pkg::DIV_W-1:0];
        end
        return o;
    endfunction

    t_div r_st [dtwp_pkg::DIV_STAGES];
    t_div n_first;

    always_comb begin
        n_first.num = i_dividend;
        n_first.rem = '0;
        n_first.dvs = i_divisor;
    end

    for (genvar s = 0; s < dtwp_pkg::DIV_STAGES; s++) begin : g_stage
        t_div n_st;
        if (s == 0) begin : g_head
            assign n_st = div_steps(n_first);
        end else begin : g_body
            assign n_st = div_steps(r_st[s-1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st;
            end
        end
    end

    assign o_quotient = r_st[dtwp_pkg::DIV_STAGES-1].num;

endmodule

[sim/disparity_to_world_point_tb.sv]
// Self-checking testbench for the disparity to world point reprojection block.
module disparity_to_world_point_tb;
    import dtwp_pkg::*;

    typedef struct {
        logic              cmd;
        logic [2:0]        slot;
        logic [31:0]       pval;
        logic [15:0]       disp;
        logic [11:0]       col;
        logic [11:0]       row;
        logic [23:0]       color;
    } t_request;

    typedef struct {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic [23:0]        color;
    } t_point;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_we;
    logic [2:0]             i_cfg_index;
    logic [30:0]            i_cfg_data;

    disparity_to_world_point dut (.*);

    // pending requests, points still owed by the block
    t_request pending_reqs[$];
    t_point   owed_points[$];
    int       n_errors = 0;
    bit       no_idle = 0;

    // shadow of the block configuration and pose
    longint cfg_focal, cfg_ccol, cfg_crow, cfg_base, cfg_dmin, cfg_dmax;
    bit     cfg_neg, cfg_back;
    longint quat[4];
    longint pos[3];
    bit     have_pose;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("disparity_to_world_point_tb: FAIL");
        $finish;
    end

    function automatic longint sat_32(input logic signed [67:0] v);
        if (v > 68'sh7FFFFFFF) return 64'sh7FFFFFFF;
        if (v < -68'sh80000000) return -64'sh80000000;
        return longint'(v);
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > (64'sd1 << 30)) return 64'sd1 << 30;
        if (v < -(64'sd1 << 30)) return -(64'sd1 << 30);
        return v;
    endfunction

    function automatic longint quat_prod(input int a, input int b);
        return (quat[a] * quat[b] + (64'sd1 << 29)) >>> 30;
    endfunction

    // rounded division, ties away from zero
    function automatic longint div_near(input longint n, input longint d);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m + d / 2) / d;
        return (n < 0) ? -m : m;
    endfunction

    // updates the pose shadow or predicts the point for one accepted request
    function automatic void track_request(input t_request r);
        longint d, den, dq, xo, yo, b[3], rm[3][3], sq;
        longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
        logic signed [67:0] acc, ned[3];
        t_point p;
        if (r.cmd == CMD_POSE) begin
            if (r.slot <= SLOT_QW) begin
                quat[r.slot] = longint'($signed(r.pval));
                have_pose = 1;
            end else if (r.slot != SLOT_NONE) begin
                pos[r.slot - SLOT_PN] = longint'($signed(r.pval));
                have_pose = 1;
            end
            return;
        end
        d = longint'($signed(r.disp));
        if (cfg_neg) d = -d;
        if (d <= 1 || !have_pose) return;
        sq = 0;
        for (int i = 0; i < 4; i++) sq += quat[i] * quat[i];
        // squares are non-negative, so a plain sum matches the early-exit test
        if (sq <= 1152921 && quat[0] * quat[0] <= 1152921 && quat[1] * quat[1] <= 1152921
            && quat[2] * quat[2] <= 1152921 && quat[3] * quat[3] <= 1152921) return;
        den = 16 * d;
        dq = (cfg_focal * cfg_base + den / 2) / den;
        if (dq < cfg_dmin || dq > cfg_dmax) return;
        xo = div_near(((longint'(r.col) << 8) - cfg_ccol) * cfg_base, den);
        yo = div_near(((longint'(r.row) << 8) - cfg_crow) * cfg_base, den);
        if (cfg_back) begin
            b[0] = sat_32(-11469 - dq);
            b[1] = sat_32(-9830 - xo);
        end else begin
            b[0] = sat_32(11469 + dq);
            b[1] = sat_32(-9830 + xo);
        end
        b[2] = sat_32(yo);
        xx = quat_prod(0, 0); yy = quat_prod(1, 1); zz = quat_prod(2, 2);
        xy = quat_prod(0, 1); xz = quat_prod(0, 2); yz = quat_prod(1, 2);
        xw = quat_prod(0, 3); yw = quat_prod(1, 3); zw = quat_prod(2, 3);
        rm[0][0] = (64'sd1 << 30) - 2 * (yy + zz);
        rm[0][1] = 2 * (xy - zw);
        rm[0][2] = 2 * (xz + yw);
        rm[1][0] = 2 * (xy + zw);
        rm[1][1] = (64'sd1 << 30) - 2 * (xx + zz);
        rm[1][2] = 2 * (yz - xw);
        rm[2][0] = 2 * (xz - yw);
        rm[2][1] = 2 * (yz + xw);
        rm[2][2] = (64'sd1 << 30) - 2 * (xx + yy);
        for (int i = 0; i < 3; i++) begin
            acc = 68'(clamp_unit(rm[i][0])) * 68'(b[0])
                + 68'(clamp_unit(rm[i][1])) * 68'(b[1])
                + 68'(clamp_unit(rm[i][2])) * 68'(b[2]);
            ned[i] = 68'(pos[i]) + ((acc + (68'sd1 << 29)) >>> 30);
        end
        p.wx = 32'(sat_32(ned[0]));
        p.wy = 32'(sat_32(-ned[1]));
        p.wz = 32'(sat_32(-ned[2]));
        p.color = r.color;
        owed_points.push_back(p);
    endfunction

    // request driver
    t_request cur_req;
    int       send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) track_request(cur_req);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_s_axis_tdata <= {5'd0, cur_req.color, cur_req.row, cur_req.col,
                                       cur_req.disp, cur_req.pval, cur_req.slot};
                    i_s_axis_tuser  <= cur_req.cmd;
                    i_s_axis_tvalid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 8);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // point monitor with random backpressure
    int recv_stall = 0;
    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (owed_points.size() == 0) begin
                    $error("unexpected point %h", o_m_axis_tdata);
                    n_errors++;
                end else begin
                    e = owed_points.pop_front();
                    if (o_m_axis_tdata[31:0] !== e.wx) begin
                        $error("world_x exp %0d got %0d", e.wx, $signed(o_m_axis_tdata[31:0]));
                        n_errors++;
                    end
                    if (o_m_axis_tdata[63:32] !== e.wy) begin
                        $error("world_y exp %0d got %0d", e.wy, $signed(o_m_axis_tdata[63:32]));
                        n_errors++;
                    end
                    if (o_m_axis_tdata[95:64] !== e.wz) begin
                        $error("world_z exp %0d got %0d", e.wz, $signed(o_m_axis_tdata[95:64]));
                        n_errors++;
                    end
                    if (o_m_axis_tdata[119:96] !== e.color) begin
                        $error("point_color exp %h got %h", e.color, o_m_axis_tdata[119:96]);
                        n_errors++;
                    end
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 8);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            i_m_axis_tready <= (recv_stall == 0);
        end
    end

    task automatic add_pose(input logic [2:0] slot, input logic [31:0] val);
        t_request r;
        r = '{cmd: CMD_POSE, slot: slot, pval: val, disp: $urandom, col: $urandom,
              row: $urandom, color: $urandom};
        pending_reqs.push_back(r);
    endtask

    task automatic add_pixel(input logic [15:0] disp, input logic [11:0] col,
                             input logic [11:0] row, input logic [23:0] color);
        t_request r;
        r = '{cmd: CMD_PIXEL, slot: $urandom, pval: $urandom, disp: disp, col: col,
              row: row, color: color};
        pending_reqs.push_back(r);
    endtask

    // waits for the pipeline to drain; dropped pixels may still be in flight
    task automatic drain();
        while (pending_reqs.size() > 0 || i_s_axis_tvalid || owed_points.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input longint val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 31'(val);
        case (idx)
            CFG_FOCAL:    cfg_focal = val & 24'hFFFFFF;
            CFG_CCOL:     cfg_ccol  = val & 20'hFFFFF;
            CFG_CROW:     cfg_crow  = val & 20'hFFFFF;
            CFG_BASELINE: cfg_base  = val & 20'hFFFFF;
            CFG_DMIN:     cfg_dmin  = val & 31'h7FFFFFFF;
            CFG_DMAX:     cfg_dmax  = val & 31'h7FFFFFFF;
            CFG_NEG:      cfg_neg   = val[0];
            CFG_BACK:     cfg_back  = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input longint f, input longint cc, input longint cr,
                              input longint bl, input longint dmn, input longint dmx,
                              input bit ng, input bit bk);
        write_reg(CFG_FOCAL, f);
        write_reg(CFG_CCOL, cc);
        write_reg(CFG_CROW, cr);
        write_reg(CFG_BASELINE, bl);
        write_reg(CFG_DMIN, dmn);
        write_reg(CFG_DMAX, dmx);
        write_reg(CFG_NEG, ng);
        write_reg(CFG_BACK, bk);
    endtask

    // mostly well-formed traffic: pixels with usable disparity, occasional pose updates
    task automatic random_traffic(input int count);
        int pick;
        logic signed [15:0] d;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                if ($urandom_range(0, 3) == 0) begin
                    add_pose(SLOT_QX, 0); add_pose(SLOT_QY, 0);
                    add_pose(SLOT_QZ, 0); add_pose(SLOT_QW, 32'h40000000);
                end else begin
                    add_pose(SLOT_QX, $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000);
                    add_pose(SLOT_QY, $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000);
                    add_pose(SLOT_QZ, $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000);
                    add_pose(SLOT_QW, $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000);
                end
                add_pose(SLOT_PN, $urandom_range(0, 32'h01FFFFFF) - 32'h01000000);
                add_pose(SLOT_PE, $urandom_range(0, 32'h01FFFFFF) - 32'h01000000);
                add_pose(SLOT_PD, $urandom_range(0, 32'h01FFFFFF) - 32'h01000000);
            end else if (pick < 9) begin
                add_pose($urandom_range(0, 7), $urandom);
            end else begin
                if (pick < 75) d = 16'($urandom_range(40, 6000));
                else if (pick < 85) d = 16'($urandom_range(0, 32767));
                else d = 16'($urandom);
                if (cfg_neg && pick < 85) d = -d;
                add_pixel(d, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_FOCAL;
        i_cfg_data      = '0;
        cfg_focal = RST_FOCAL; cfg_ccol = RST_CCOL; cfg_crow = RST_CROW;
        cfg_base = RST_BASELINE; cfg_dmin = RST_DMIN; cfg_dmax = RST_DMAX;
        cfg_neg = 0; cfg_back = 0;
        for (int i = 0; i < 4; i++) quat[i] = 0;
        for (int i = 0; i < 3; i++) pos[i] = 0;
        have_pose = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: no pose yet, ignored slot, too-small quaternion
        add_pixel(16'd100, 12'd320, 12'd240, 24'h123456);
        add_pose(SLOT_NONE, 32'h40000000);
        add_pixel(16'd100, 12'd320, 12'd240, 24'h654321);
        add_pose(SLOT_QX, 32'd1000);
        add_pixel(16'd100, 12'd10, 12'd20, 24'hABCDEF);
        add_pose(SLOT_QX, 32'd1074);
        add_pixel(16'd100, 12'd10, 12'd20, 24'hFEDCBA);
        // identity rotation
        add_pose(SLOT_QX, 32'd0);
        add_pose(SLOT_QW, 32'h40000000);
        add_pixel(16'd1, 12'd0, 12'd0, 24'h0);
        add_pixel(16'd2, 12'd0, 12'd0, 24'h0);
        add_pixel(16'd100, 12'd0, 12'd0, 24'h000000);
        add_pixel(16'd100, 12'hFFF, 12'hFFF, 24'hFFFFFF);
        add_pixel(-16'sd5, 12'd1, 12'd1, 24'h1);
        add_pixel(16'h7FFF, 12'd5, 12'd5, 24'h2);
        add_pixel(16'h8000, 12'd5, 12'd5, 24'h3);
        // non-unit quaternion, entries clamp
        add_pose(SLOT_QX, 32'h7FFFFFFF);
        add_pose(SLOT_QY, 32'h80000000);
        add_pixel(16'd300, 12'd100, 12'd900, 24'h808080);
        // extreme position, world coordinates saturate
        add_pose(SLOT_PN, 32'h7FFFFFFF);
        add_pose(SLOT_PE, 32'h80000000);
        add_pose(SLOT_PD, 32'h80000000);
        add_pixel(16'd60, 12'd4000, 12'd3, 24'h7F7F7F);
        add_pose(SLOT_QX, 0); add_pose(SLOT_QY, 0);
        add_pose(SLOT_PN, 0); add_pose(SLOT_PE, 0); add_pose(SLOT_PD, 0);
        random_traffic(40);
        // sender holds until every owed point has arrived
        drain();

        set_config(24'hFFFFFF, 0, 20'hFFFFF, 20'hFFFFF, 0, 31'h7FFFFFFF, 1, 1);
        random_traffic(60);
        drain();

        no_idle = 1;
        set_config(1, 20'hFFFFF, 0, 0, 0, 31'h7FFFFFFF, 0, 0);
        random_traffic(40);
        drain();
        no_idle = 0;

        set_config(RST_FOCAL, RST_CCOL, RST_CROW, RST_BASELINE, 31'h7FFFFFFF, 0, 0, 1);
        random_traffic(25);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_config($urandom_range(1, 24'hFFFFFF), $urandom_range(0, 20'hFFFFF),
                       $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                       $urandom_range(0, 65536), $urandom_range(31'h01000000, 31'h7FFFFFFF),
                       $urandom_range(0, 1), $urandom_range(0, 1));
            no_idle = (ph == 2);
            random_traffic(45);
            drain();
        end

        if (n_errors == 0) begin
            $display("disparity_to_world_point_tb: PASS");
        end else begin
            $display("disparity_to_world_point_tb: FAIL");
        end
        $finish;
    end

endmodule
